>>> hdl/lcsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsf_pkg
// Shared sizes, codes and types for the line change span finder.
// ----------------------------------------------------------------------------
package lcsf_pkg;

  localparam int MAX_LEN   = 256;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int OFS_W     = 10;
  localparam int BYTE_W    = 8;
  localparam int PCT_W     = 7;
  localparam int PROD_W    = LEN_W + PCT_W;
  localparam int PCT_SCALE = 100;

  localparam logic [PCT_W-1:0] PCT_RESET    = PCT_W'(30);
  localparam logic [OFS_W-1:0] NO_HIGHLIGHT = '1;

  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_SECOND  = 2'd1,
    KIND_COMPARE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  // Access request from the controller to the two line stores.
  typedef struct packed {
    logic              we_first;
    logic              we_second;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_first;
    logic [ADDR_W-1:0] raddr_second;
  } store_req_t;

endpackage

>>> hdl/line_change_span_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_change_span_finder
// Loads two lines byte by byte and reports the changed span in each line.
// ----------------------------------------------------------------------------
// Byte loads are taken one word per cycle while busy is low. A compare walks
// the stores one byte pair at a time, each through a read state and a compare
// state (one read port per line, registered read data); busy is high
// throughout and the result strobe is high in the same cycle that busy falls.
// The receiver cannot stall.
// Reset clears both lengths and the overflow flag and sets the percentage to 30;
// the store contents are undefined until written.
module line_change_span_finder import lcsf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind,
  input  logic [BYTE_W-1:0]       byte_value,
  input  logic                    cfg_write,
  input  logic [PCT_W-1:0]        cfg_data,
  output logic                    done,
  output logic signed [OFS_W-1:0] first_start,
  output logic signed [OFS_W-1:0] first_end,
  output logic signed [OFS_W-1:0] second_start,
  output logic signed [OFS_W-1:0] second_end,
  output logic                    overflow
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_PRE_RD  = 8'b0000_0010,
    S_PRE_CMP = 8'b0000_0100,
    S_SUF_RD  = 8'b0000_1000,
    S_SUF_CMP = 8'b0001_0000,
    S_SIM_RD  = 8'b0010_0000,
    S_SIM_CMP = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  first_length;
  logic [LEN_W-1:0]  second_length;
  logic              truncated;
  logic [PCT_W-1:0]  similarity_percent;
  logic [LEN_W-1:0]  shorter;
  logic [LEN_W-1:0]  pre;
  logic [LEN_W-1:0]  suf;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  shared;
  logic              sim_ran;

  store_req_t        req;
  logic [BYTE_W-1:0] rdata_first;
  logic [BYTE_W-1:0] rdata_second;

  logic              accept;
  logic              load_first;
  logic              load_second;
  logic              suf_go;
  logic              sim_needed;
  logic [LEN_W:0]    used_first;
  logic [LEN_W:0]    used_second;
  logic [LEN_W-1:0]  tail_first;
  logic [LEN_W-1:0]  tail_second;
  logic [PROD_W-1:0] shared_scaled;
  logic [PROD_W-1:0] needed;
  logic              no_highlight;
  logic [LEN_W-1:0]  end_first;
  logic [LEN_W-1:0]  end_second;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign load_first  = accept && (kind_t'(kind) == KIND_FIRST);
  assign load_second = accept && (kind_t'(kind) == KIND_SECOND);

  // The suffix may not reach back into the prefix on either line.
  assign used_first  = {1'b0, pre} + {1'b0, suf};
  assign used_second = {1'b0, pre} + {1'b0, suf};
  assign suf_go      = (used_first < {1'b0, first_length}) &&
                       (used_second < {1'b0, second_length});
  assign tail_first  = first_length - suf - LEN_W'(1);
  assign tail_second = second_length - suf - LEN_W'(1);
  assign sim_needed  = (pre == '0) && (suf == '0) &&
                       (first_length != '0) && (second_length != '0);

  assign shared_scaled = PROD_W'(shared) * PROD_W'(PCT_SCALE);
  assign needed        = PROD_W'(similarity_percent) * PROD_W'(shorter);
  assign no_highlight  = sim_ran && (shared_scaled < needed);
  assign end_first     = first_length - suf;
  assign end_second    = second_length - suf;

  always_comb begin
    req.we_first     = load_first && (first_length < LEN_W'(MAX_LEN));
    req.we_second    = load_second && (second_length < LEN_W'(MAX_LEN));
    req.waddr        = load_first ? first_length[ADDR_W-1:0]
                                  : second_length[ADDR_W-1:0];
    req.wdata        = byte_value;
    req.raddr_first  = pre[ADDR_W-1:0];
    req.raddr_second = pre[ADDR_W-1:0];
    if (state == S_SUF_RD) begin
      req.raddr_first  = tail_first[ADDR_W-1:0];
      req.raddr_second = tail_second[ADDR_W-1:0];
    end else if (state == S_SIM_RD) begin
      req.raddr_first  = idx[ADDR_W-1:0];
      req.raddr_second = idx[ADDR_W-1:0];
    end
  end

  lcsf_store u_store (
    .clk          (clk),
    .req          (req),
    .rdata_first  (rdata_first),
    .rdata_second (rdata_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      first_length       <= '0;
      second_length      <= '0;
      truncated          <= 1'b0;
      similarity_percent <= PCT_RESET;
      sim_ran            <= 1'b0;
      done               <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        similarity_percent <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (load_first) begin
            if (req.we_first) begin
              first_length <= first_length + LEN_W'(1);
            end else begin
              truncated <= 1'b1;
            end
          end
          if (load_second) begin
            if (req.we_second) begin
              second_length <= second_length + LEN_W'(1);
            end else begin
              truncated <= 1'b1;
            end
          end
          if (accept && (kind_t'(kind) == KIND_COMPARE)) begin
            shorter <= (first_length < second_length) ? first_length : second_length;
            pre     <= '0;
            suf     <= '0;
            sim_ran <= 1'b0;
            state   <= S_PRE_RD;
          end
        end
        S_PRE_RD: begin
          state <= (pre < shorter) ? S_PRE_CMP : S_SUF_RD;
        end
        S_PRE_CMP: begin
          if (rdata_first == rdata_second) begin
            pre   <= pre + LEN_W'(1);
            state <= S_PRE_RD;
          end else begin
            state <= S_SUF_RD;
          end
        end
        S_SUF_RD: begin
          if (suf_go) begin
            state <= S_SUF_CMP;
          end else if (sim_needed) begin
            idx     <= '0;
            shared  <= '0;
            sim_ran <= 1'b1;
            state   <= S_SIM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SUF_CMP: begin
          // A mismatch ends the walk through the same exit checks.
          if (rdata_first == rdata_second) begin
            suf <= suf + LEN_W'(1);
          end
          if (rdata_first == rdata_second) begin
            state <= S_SUF_RD;
          end else if (sim_needed) begin
            idx     <= '0;
            shared  <= '0;
            sim_ran <= 1'b1;
            state   <= S_SIM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SIM_RD: begin
          state <= (idx < shorter) ? S_SIM_CMP : S_DONE;
        end
        S_SIM_CMP: begin
          if (rdata_first == rdata_second) begin
            shared <= shared + LEN_W'(1);
          end
          idx   <= idx + LEN_W'(1);
          state <= S_SIM_RD;
        end
        S_DONE: begin
          done          <= 1'b1;
          first_length  <= '0;
          second_length <= '0;
          truncated     <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word, held from the end of a compare until the next one.
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      overflow <= truncated;
      if (no_highlight) begin
        first_start  <= NO_HIGHLIGHT;
        first_end    <= NO_HIGHLIGHT;
        second_start <= NO_HIGHLIGHT;
        second_end   <= NO_HIGHLIGHT;
      end else begin
        first_start  <= OFS_W'(pre);
        first_end    <= OFS_W'(end_first);
        second_start <= OFS_W'(pre);
        second_end   <= OFS_W'(end_second);
      end
    end
  end

endmodule

>>> hdl/lcsf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsf_store
// The two line stores: one write port shared by loads, one registered read
// port per line.
// ----------------------------------------------------------------------------
module lcsf_store import lcsf_pkg::*; (
  input  logic              clk,
  input  store_req_t        req,
  output logic [BYTE_W-1:0] rdata_first,
  output logic [BYTE_W-1:0] rdata_second
);

  logic [BYTE_W-1:0] first_mem  [MAX_LEN];
  logic [BYTE_W-1:0] second_mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.we_first) begin
      first_mem[req.waddr] <= req.wdata;
    end
    rdata_first <= first_mem[req.raddr_first];
  end

  always_ff @(posedge clk) begin
    if (req.we_second) begin
      second_mem[req.waddr] <= req.wdata;
    end
    rdata_second <= second_mem[req.raddr_second];
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds line pairs, byte by byte, into the line change span finder and
// compares every reported span with a scoreboard that tracks both lines.
// ----------------------------------------------------------------------------
module testbench;
  import lcsf_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PAIRS_PER_SET = 20;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] first_start;
    logic signed [OFS_W-1:0] first_end;
    logic signed [OFS_W-1:0] second_start;
    logic signed [OFS_W-1:0] second_end;
    logic                    overflow;
  } span_t;

  class span_scoreboard;
    byte_t first_store [MAX_LEN];
    byte_t second_store [MAX_LEN];
    int    first_len;
    int    second_len;
    bit    dropped;
    int    percent;
    span_t expected_spans [$];
    int    errors;

    function new();
      first_len  = 0;
      second_len = 0;
      dropped    = 1'b0;
      percent    = int'(PCT_RESET);
      errors     = 0;
    endfunction

    function void set_percent(int p);
      percent = p;
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction

    // Updates the line state for an accepted word and, on a compare, queues
    // the span that the block must report.
    function void note_word(kind_t k, byte_t b);
      int    shorter;
      int    pre;
      int    suf;
      int    shared;
      span_t span;
      if (k == KIND_FIRST) begin
        if (first_len < MAX_LEN) begin
          first_store[first_len] = b;
          first_len++;
        end else begin
          dropped = 1'b1;
        end
      end else if (k == KIND_SECOND) begin
        if (second_len < MAX_LEN) begin
          second_store[second_len] = b;
          second_len++;
        end else begin
          dropped = 1'b1;
        end
      end else if (k == KIND_COMPARE) begin
        shorter = (first_len < second_len) ? first_len : second_len;
        pre = 0;
        while (pre < shorter && first_store[pre] == second_store[pre]) pre++;
        // The suffix may not reach back into the prefix of either line.
        suf = 0;
        while (suf < first_len - pre && suf < second_len - pre &&
               first_store[first_len - 1 - suf] == second_store[second_len - 1 - suf])
          suf++;
        span.first_start  = OFS_W'(pre);
        span.first_end    = OFS_W'(first_len - suf);
        span.second_start = OFS_W'(pre);
        span.second_end   = OFS_W'(second_len - suf);
        if (pre == 0 && suf == 0 && first_len > 0 && second_len > 0) begin
          shared = 0;
          for (int i = 0; i < shorter; i++)
            if (first_store[i] == second_store[i]) shared++;
          if (shared * PCT_SCALE < percent * shorter) begin
            span.first_start  = NO_HIGHLIGHT;
            span.first_end    = NO_HIGHLIGHT;
            span.second_start = NO_HIGHLIGHT;
            span.second_end   = NO_HIGHLIGHT;
          end
        end
        span.overflow = dropped;
        expected_spans.push_back(span);
        first_len  = 0;
        second_len = 0;
        dropped    = 1'b0;
      end
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(span_t got);
      span_t want;
      if (expected_spans.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_spans.pop_front();
      check_field("first_start", want.first_start, got.first_start);
      check_field("first_end", want.first_end, got.first_end);
      check_field("second_start", want.second_start, got.second_start);
      check_field("second_end", want.second_end, got.second_end);
      check_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              kind = KIND_FIRST;
  logic [BYTE_W-1:0]       byte_value = '0;
  logic                    cfg_write = 1'b0;
  logic [PCT_W-1:0]        cfg_data = '0;
  logic                    busy;
  logic                    done;
  logic signed [OFS_W-1:0] first_start;
  logic signed [OFS_W-1:0] first_end;
  logic signed [OFS_W-1:0] second_start;
  logic signed [OFS_W-1:0] second_end;
  logic                    overflow;

  span_scoreboard sb = new();
  byte_t          first_text [$];
  byte_t          second_text [$];
  int             items_sent = 0;
  int             cycle_count = 0;
  bit             calm = 1'b0;

  line_change_span_finder u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .byte_value   (byte_value),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .first_start  (first_start),
    .first_end    (first_end),
    .second_start (second_start),
    .second_end   (second_end),
    .overflow     (overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result({first_start, first_end, second_start, second_end, overflow});
  end

  // Start is left high after acceptance so that back-to-back words need no
  // extra edge; pauses and drains lower it.
  task automatic send_word(kind_t k, byte_t b);
    @(negedge clk);
    start      <= 1'b1;
    kind       <= k;
    byte_value <= b;
    do @(posedge clk); while (busy);
    sb.note_word(k, b);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(99) < 7) begin
      @(negedge clk);
      start      <= 1'b0;
      kind       <= 2'($urandom);
      byte_value <= byte_t'($urandom);
      repeat ($urandom_range(2)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_percent(int p);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= PCT_W'(p);
    @(posedge clk);
    sb.set_percent(p);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int rand_len(bit big);
    return big ? $urandom_range(MAX_LEN - 4, MAX_LEN + 4) : $urandom_range(0, 10);
  endfunction

  // Builds one pair of lines whose relation depends on the chosen shape.
  task automatic compose_pair(int shape, bit big);
    int    head;
    int    tail;
    int    n;
    byte_t fill;
    first_text.delete();
    second_text.delete();
    case (shape)
      0: begin
        n = rand_len(big);
        repeat (n) begin
          fill = byte_t'($urandom);
          first_text.push_back(fill);
          second_text.push_back(fill);
        end
      end
      1: begin
        head = big ? $urandom_range(100, 140) : $urandom_range(0, 4);
        tail = big ? $urandom_range(100, 140) : $urandom_range(0, 4);
        repeat (head) begin
          fill = byte_t'($urandom);
          first_text.push_back(fill);
          second_text.push_back(fill);
        end
        repeat ($urandom_range(0, big ? 20 : 4)) first_text.push_back(byte_t'($urandom));
        repeat ($urandom_range(0, big ? 20 : 4)) second_text.push_back(byte_t'($urandom));
        repeat (tail) begin
          fill = byte_t'($urandom);
          first_text.push_back(fill);
          second_text.push_back(fill);
        end
      end
      2: begin
        repeat (rand_len(big)) first_text.push_back(byte_t'($urandom));
        repeat (rand_len(big)) second_text.push_back(byte_t'($urandom));
      end
      3: begin
        // Two-letter alphabet with differing ends, so that the similarity
        // count decides whether highlighting survives.
        repeat (big ? rand_len(1'b1) : $urandom_range(1, 10))
          first_text.push_back(8'h41 + byte_t'($urandom_range(1)));
        repeat (big ? rand_len(1'b1) : $urandom_range(1, 10))
          second_text.push_back(8'h41 + byte_t'($urandom_range(1)));
        if (second_text[0] == first_text[0]) second_text[0] = 8'h30;
        if (second_text[$] == first_text[$]) second_text[$] = 8'h31;
      end
      4: begin
        if ($urandom_range(1)) repeat (rand_len(big)) first_text.push_back(byte_t'($urandom));
        else repeat (rand_len(big)) second_text.push_back(byte_t'($urandom));
      end
      5: begin
        n = rand_len(big);
        repeat (n) begin
          fill = byte_t'($urandom);
          first_text.push_back(fill);
          second_text.push_back(fill);
        end
        if ($urandom_range(1)) repeat ($urandom_range(1, 3)) first_text.push_back(byte_t'($urandom));
        else repeat ($urandom_range(1, 3)) second_text.push_back(byte_t'($urandom));
      end
      default: begin
        fill = byte_t'($urandom);
        repeat (rand_len(big)) first_text.push_back(fill);
        repeat (rand_len(big)) second_text.push_back(fill);
      end
    endcase
  endtask

  task automatic send_pair();
    while (first_text.size() != 0 || second_text.size() != 0) begin
      if ($urandom_range(99) < 3) send_word(KIND_UNUSED, byte_t'($urandom));
      if (second_text.size() == 0 || (first_text.size() != 0 && $urandom_range(1)))
        send_word(KIND_FIRST, first_text.pop_front());
      else
        send_word(KIND_SECOND, second_text.pop_front());
      maybe_pause();
    end
    send_word(KIND_COMPARE, byte_t'($urandom));
    maybe_pause();
  endtask

  initial begin
    int pct_plan [6];
    int pair_no;
    int phase;
    pct_plan = '{0, 100, 127, 50, 1, 99};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset percentage.
    send_word(KIND_COMPARE, 8'hFF);
    send_word(KIND_FIRST, 8'h00);
    send_word(KIND_FIRST, 8'hFF);
    send_word(KIND_SECOND, 8'h00);
    send_word(KIND_SECOND, 8'hFF);
    send_word(KIND_COMPARE, 8'h00);
    send_word(KIND_FIRST, 8'h00);
    send_word(KIND_SECOND, 8'hFF);
    send_word(KIND_COMPARE, 8'hA5);
    send_word(KIND_UNUSED, 8'h55);
    send_word(KIND_SECOND, 8'hAA);
    send_word(KIND_SECOND, 8'h55);
    send_word(KIND_COMPARE, 8'h5A);
    send_word(KIND_FIRST, 8'h61);
    send_word(KIND_FIRST, 8'h61);
    send_word(KIND_SECOND, 8'h61);
    send_word(KIND_SECOND, 8'h61);
    send_word(KIND_SECOND, 8'h61);
    send_word(KIND_COMPARE, 8'h00);
    send_word(KIND_FIRST, 8'h41);
    send_word(KIND_FIRST, 8'h42);
    send_word(KIND_FIRST, 8'h43);
    send_word(KIND_SECOND, 8'h58);
    send_word(KIND_SECOND, 8'h42);
    send_word(KIND_SECOND, 8'h59);
    send_word(KIND_COMPARE, 8'h00);

    pair_no = 0;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (pair_no % PAIRS_PER_SET == 0) begin
        drain();
        write_percent(phase < 6 ? pct_plan[phase] : $urandom_range(0, 127));
        phase++;
      end
      calm = (pair_no >= 40 && pair_no < 70);
      if (pair_no == 3) begin
        // One line just past capacity, so the overflow flag must be seen.
        compose_pair(0, 1'b1);
        while (first_text.size() <= MAX_LEN) first_text.push_back(byte_t'($urandom));
      end else if (pair_no == 8) begin
        compose_pair(5, 1'b1);
      end else begin
        compose_pair($urandom_range(6), $urandom_range(49) == 0);
      end
      send_pair();
      pair_no++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
